>>> sv/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Types, constants and table lookups for the C source lexer: lexer modes,
// the result record, operator and keyword tables and character classes.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int WBUF_DEPTH  = 16;
  localparam int WBUF_IDX_BITS = $clog2(WBUF_DEPTH);
  localparam int LENGTH_BITS = 16;
  localparam int PAREN_BITS  = 16;
  localparam int VALUE_BITS  = 63;
  localparam int KEY_BYTES   = 13;
  localparam int KEY_BITS    = 8 * KEY_BYTES;
  localparam int NUM_KW      = 20;
  localparam int NUM_DROP    = 4;
  localparam int KW_BASE     = 46;
  localparam int MAX_RES     = 4;
  localparam int RQ_DEPTH    = 8;
  localparam int RQ_PTR_BITS = $clog2(RQ_DEPTH);

  localparam logic [VALUE_BITS-1:0]  VAL_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [PAREN_BITS-1:0]  PAREN_MAX = '1;

  localparam logic [2:0] KIND_RSV   = 3'd0;
  localparam logic [2:0] KIND_IDENT = 3'd1;
  localparam logic [2:0] KIND_NUM   = 3'd2;
  localparam logic [2:0] KIND_CHAR  = 3'd3;
  localparam logic [2:0] KIND_STR   = 3'd4;
  localparam logic [2:0] KIND_EOF   = 3'd5;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_BYTE  = 2'd1;
  localparam logic [1:0] ERR_QUOTE = 2'd2;
  localparam logic [1:0] ERR_UNTERM = 2'd3;

  localparam logic [6:0] CODE_NONE = 7'd0;

  typedef enum logic [15:0] {
    LM_IDLE       = 16'h0001,
    LM_WORD       = 16'h0002,
    LM_DEC        = 16'h0004,
    LM_ZEROX      = 16'h0008,
    LM_HEX        = 16'h0010,
    LM_OPS        = 16'h0020,
    LM_LINE       = 16'h0040,
    LM_BLOCK      = 16'h0080,
    LM_BLOCK_STAR = 16'h0100,
    LM_CHAR_OPEN  = 16'h0200,
    LM_CHAR_ESC   = 16'h0400,
    LM_CHAR_CLOSE = 16'h0800,
    LM_STR        = 16'h1000,
    LM_STR_ESC    = 16'h2000,
    LM_ATTR_WAIT  = 16'h4000,
    LM_ATTR_PAREN = 16'h8000
  } lex_mode_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [6:0]             code;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [VALUE_BITS-1:0]  value;
    logic [1:0]             err;
    logic                   last;
  } result_t;

  typedef logic [WBUF_DEPTH-1:0][7:0] wbuf_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] code;
  } op_hit_t;

  typedef enum logic [1:0] {
    WC_IDENT = 2'd0,
    WC_DROP  = 2'd1,
    WC_ATTR  = 2'd2,
    WC_KW    = 2'd3
  } wclass_act_t;

  typedef struct packed {
    wclass_act_t act;
    logic [6:0]  code;
  } wclass_t;

  function automatic logic [KEY_BITS-1:0] lalign(logic [KEY_BITS-1:0] s, int n);
    return s << (8 * (KEY_BYTES - n));
  endfunction

  localparam logic [KEY_BITS-1:0] KW_TXT [NUM_KW] = '{
    lalign("do", 2), lalign("while", 5), lalign("switch", 6), lalign("case", 4),
    lalign("default", 7), lalign("continue", 8), lalign("break", 5),
    lalign("for", 3), lalign("return", 6), lalign("if", 2), lalign("else", 4),
    lalign("struct", 6), lalign("enum", 4), lalign("union", 5),
    lalign("typedef", 7), lalign("const", 5), lalign("static", 6),
    lalign("extern", 6), lalign("sizeof", 6), lalign("__inline", 8)
  };

  localparam logic [KEY_BITS-1:0] DROP_TXT [NUM_DROP] = '{
    lalign("signed", 6), lalign("volatile", 8), lalign("__extension__", 13),
    lalign("__restrict", 10)
  };

  localparam logic [KEY_BITS-1:0] ATTR_TXT = lalign("__attribute__", 13);

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (is_digit(c)) t = c - 8'h30;
    else if (c >= "a" && c <= "f") t = c - 8'h57;
    else if (c >= "A" && c <= "F") t = c - 8'h37;
    return t[3:0];
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || c == 8'h0a || c == 8'h09 || c == 8'h0d || c == 8'h00;
  endfunction

  function automatic logic [7:0] escape_of(logic [7:0] c);
    logic [7:0] r;
    case (c)
      "0":     r = 8'd0;
      "a":     r = 8'd7;
      "b":     r = 8'd8;
      "f":     r = 8'd12;
      "n":     r = 8'd10;
      "r":     r = 8'd13;
      "t":     r = 8'd9;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic op_hit_t op1_code(logic [7:0] c);
    op_hit_t r;
    r.hit = 1'b1;
    case (c)
      "=":     r.code = 7'd22;
      ",":     r.code = 7'd23;
      ".":     r.code = 7'd24;
      "(":     r.code = 7'd25;
      ")":     r.code = 7'd26;
      "{":     r.code = 7'd27;
      "}":     r.code = 7'd28;
      "[":     r.code = 7'd29;
      "]":     r.code = 7'd30;
      "<":     r.code = 7'd31;
      ">":     r.code = 7'd32;
      "+":     r.code = 7'd33;
      "-":     r.code = 7'd34;
      "*":     r.code = 7'd35;
      "/":     r.code = 7'd36;
      "%":     r.code = 7'd37;
      "^":     r.code = 7'd38;
      ";":     r.code = 7'd39;
      "&":     r.code = 7'd40;
      "|":     r.code = 7'd41;
      "~":     r.code = 7'd42;
      "!":     r.code = 7'd43;
      "?":     r.code = 7'd44;
      ":":     r.code = 7'd45;
      default: begin
        r.hit  = 1'b0;
        r.code = CODE_NONE;
      end
    endcase
    return r;
  endfunction

  function automatic op_hit_t op2_code(logic [7:0] a, logic [7:0] b);
    op_hit_t r;
    r.hit = 1'b1;
    case ({a, b})
      "==":    r.code = 7'd3;
      "!=":    r.code = 7'd4;
      "<=":    r.code = 7'd5;
      ">=":    r.code = 7'd6;
      "+=":    r.code = 7'd7;
      "-=":    r.code = 7'd8;
      "*=":    r.code = 7'd9;
      "/=":    r.code = 7'd10;
      "&=":    r.code = 7'd11;
      "|=":    r.code = 7'd12;
      "^=":    r.code = 7'd13;
      "~=":    r.code = 7'd14;
      "++":    r.code = 7'd15;
      "--":    r.code = 7'd16;
      "&&":    r.code = 7'd17;
      "||":    r.code = 7'd18;
      ">>":    r.code = 7'd19;
      "<<":    r.code = 7'd20;
      "->":    r.code = 7'd21;
      default: begin
        r.hit  = 1'b0;
        r.code = CODE_NONE;
      end
    endcase
    return r;
  endfunction

  function automatic op_hit_t op3_code(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    op_hit_t r;
    r.hit = 1'b1;
    case ({a, b, c})
      ">>=":   r.code = 7'd0;
      "<<=":   r.code = 7'd1;
      "...":   r.code = 7'd2;
      default: begin
        r.hit  = 1'b0;
        r.code = CODE_NONE;
      end
    endcase
    return r;
  endfunction

  function automatic wclass_t word_class(wbuf_t b, logic [LENGTH_BITS-1:0] n);
    logic [KEY_BITS-1:0] key;
    wclass_t r;
    key    = '0;
    r.act  = WC_IDENT;
    r.code = CODE_NONE;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (LENGTH_BITS'(i) < n) key[KEY_BITS-1-8*i -: 8] = b[i];
    end
    if (n <= LENGTH_BITS'(KEY_BYTES)) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if (key == KW_TXT[i]) begin
          r.act  = WC_KW;
          r.code = 7'(KW_BASE + i);
        end
      end
      if (key == ATTR_TXT) r.act = WC_ATTR;
      for (int i = 0; i < NUM_DROP; i++) begin
        if (key == DROP_TXT[i]) r.act = WC_DROP;
      end
    end
    return r;
  endfunction

  function automatic logic [VALUE_BITS-1:0] sat_accum(logic [VALUE_BITS-1:0] acc,
                                                      logic base16, logic [3:0] d);
    logic [VALUE_BITS+3:0] w;
    logic [VALUE_BITS+3:0] s;
    w = {4'b0, acc};
    if (base16) s = (w << 4) + {{VALUE_BITS{1'b0}}, d};
    else s = (w << 3) + (w << 1) + {{VALUE_BITS{1'b0}}, d};
    return (s > {4'b0, VAL_MAX}) ? VAL_MAX : s[VALUE_BITS-1:0];
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_inc(logic [LENGTH_BITS-1:0] n);
    return (n == LEN_MAX) ? n : n + LENGTH_BITS'(1);
  endfunction

  function automatic result_t mk_res(logic [2:0] kind, logic [6:0] code,
                                     logic [OFFSET_BITS-1:0] start,
                                     logic [LENGTH_BITS-1:0] len,
                                     logic [VALUE_BITS-1:0] value, logic [1:0] err);
    result_t r;
    r.kind  = kind;
    r.code  = code;
    r.start = start;
    r.len   = len;
    r.value = value;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

>>> sv/c_source_lexer.sv
// ----------------------------------------------------------------------------
// c_source_lexer
// Streaming C lexer: one source byte per transaction in, token records out
// through a small result queue.
// ----------------------------------------------------------------------------
// A result enters the result queue when its byte is taken and is offered once
// older results have left. Throughput: one byte per cycle while the 8-entry
// queue has room for the up to four results one byte can cause; results leave
// at one per cycle while out_ready is high. Reset is synchronous, active low;
// it returns the lexer to idle at offset zero and empties the result queue.
module c_source_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_kind,
  output logic [6:0]  out_token_code,
  output logic [csl_pkg::OFFSET_BITS-1:0] out_start_offset,
  output logic [csl_pkg::LENGTH_BITS-1:0] out_token_length,
  output logic [csl_pkg::VALUE_BITS-1:0]  out_token_value,
  output logic [1:0]  out_error_code,
  output logic        out_last_result
);

  csl_pkg::lex_mode_t                   mode_r, mode_nxt;
  logic [1:0]                           pcnt_r, pcnt_nxt;
  logic [7:0]                           pop0_r, pop0_nxt, pop1_r, pop1_nxt;
  csl_pkg::wbuf_t                       wbuf_r, wbuf_nxt;
  logic [csl_pkg::LENGTH_BITS-1:0]      wlen_r, wlen_nxt;
  logic [csl_pkg::VALUE_BITS-1:0]       acc_r, acc_nxt;
  logic [csl_pkg::OFFSET_BITS-1:0]      tstart_r, tstart_nxt;
  logic [csl_pkg::OFFSET_BITS-1:0]      boff_r;
  logic [csl_pkg::PAREN_BITS-1:0]       pdepth_r, pdepth_nxt;
  logic [7:0]                           prev_r;

  csl_pkg::result_t                     res [csl_pkg::MAX_RES];
  logic [2:0]                           nres;
  logic [1:0]                           eof_err;
  logic                                 live;
  logic [7:0]                           c;
  csl_pkg::op_hit_t                     oh;
  csl_pkg::wclass_t                     wc;

  csl_pkg::result_t                     rq_r [csl_pkg::RQ_DEPTH];
  logic [csl_pkg::RQ_PTR_BITS-1:0]      wptr_r, rptr_r;
  logic [csl_pkg::RQ_PTR_BITS:0]        rcnt_r;
  logic                                 in_fire, out_fire;
  csl_pkg::result_t                     head;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = rcnt_r <= (csl_pkg::RQ_PTR_BITS+1)'(csl_pkg::RQ_DEPTH - csl_pkg::MAX_RES);
  assign c = in_char_byte;

  always_comb begin
    mode_nxt   = mode_r;
    pcnt_nxt   = pcnt_r;
    pop0_nxt   = pop0_r;
    pop1_nxt   = pop1_r;
    wbuf_nxt   = wbuf_r;
    wlen_nxt   = wlen_r;
    acc_nxt    = acc_r;
    tstart_nxt = tstart_r;
    pdepth_nxt = pdepth_r;
    nres       = 3'd0;
    eof_err    = csl_pkg::ERR_NONE;
    live       = 1'b1;
    oh         = '0;
    wc         = '0;
    for (int i = 0; i < csl_pkg::MAX_RES; i++) res[i] = '0;

    if (in_end_of_text) begin
      case (mode_r)
        csl_pkg::LM_WORD: begin
          wc = csl_pkg::word_class(wbuf_r, wlen_r);
          if (wc.act == csl_pkg::WC_KW) begin
            res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_RSV, wc.code, tstart_r, wlen_r,
                                             '0, csl_pkg::ERR_NONE);
            nres = nres + 3'd1;
          end else if (wc.act == csl_pkg::WC_IDENT) begin
            res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_IDENT, csl_pkg::CODE_NONE,
                                             tstart_r, wlen_r, '0, csl_pkg::ERR_NONE);
            nres = nres + 3'd1;
          end
        end
        csl_pkg::LM_DEC, csl_pkg::LM_HEX: begin
          res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NUM, csl_pkg::CODE_NONE, tstart_r,
                                           wlen_r, acc_r, csl_pkg::ERR_NONE);
          nres = nres + 3'd1;
        end
        csl_pkg::LM_ZEROX: begin
          res[0] = csl_pkg::mk_res(csl_pkg::KIND_NUM, csl_pkg::CODE_NONE, tstart_r,
                                   csl_pkg::LENGTH_BITS'(1), '0, csl_pkg::ERR_NONE);
          res[1] = csl_pkg::mk_res(csl_pkg::KIND_IDENT, csl_pkg::CODE_NONE,
                                   tstart_r + csl_pkg::OFFSET_BITS'(1),
                                   csl_pkg::LENGTH_BITS'(1), '0, csl_pkg::ERR_NONE);
          nres = 3'd2;
        end
        csl_pkg::LM_OPS: begin
          if (pcnt_r == 2'd1) begin
            oh = csl_pkg::op1_code(pop0_r);
            res[0] = csl_pkg::mk_res(csl_pkg::KIND_RSV, oh.code, tstart_r,
                                     csl_pkg::LENGTH_BITS'(1), '0, csl_pkg::ERR_NONE);
            nres = 3'd1;
          end else if (pcnt_r == 2'd2) begin
            if (pop0_r == ".") begin
              oh = csl_pkg::op1_code(pop0_r);
              res[0] = csl_pkg::mk_res(csl_pkg::KIND_RSV, oh.code, tstart_r,
                                       csl_pkg::LENGTH_BITS'(1), '0, csl_pkg::ERR_NONE);
              res[1] = csl_pkg::mk_res(csl_pkg::KIND_RSV, oh.code,
                                       tstart_r + csl_pkg::OFFSET_BITS'(1),
                                       csl_pkg::LENGTH_BITS'(1), '0, csl_pkg::ERR_NONE);
              nres = 3'd2;
            end else begin
              oh = csl_pkg::op2_code(pop0_r, pop1_r);
              res[0] = csl_pkg::mk_res(csl_pkg::KIND_RSV, oh.code, tstart_r,
                                       csl_pkg::LENGTH_BITS'(2), '0, csl_pkg::ERR_NONE);
              nres = 3'd1;
            end
          end
        end
        csl_pkg::LM_CHAR_OPEN, csl_pkg::LM_CHAR_ESC, csl_pkg::LM_CHAR_CLOSE: begin
          res[0] = csl_pkg::mk_res(csl_pkg::KIND_CHAR, csl_pkg::CODE_NONE, tstart_r, wlen_r,
                                   acc_r, csl_pkg::ERR_UNTERM);
          nres    = 3'd1;
          eof_err = csl_pkg::ERR_UNTERM;
        end
        csl_pkg::LM_STR, csl_pkg::LM_STR_ESC: begin
          res[0] = csl_pkg::mk_res(csl_pkg::KIND_STR, csl_pkg::CODE_NONE, tstart_r, wlen_r,
                                   '0, csl_pkg::ERR_UNTERM);
          nres    = 3'd1;
          eof_err = csl_pkg::ERR_UNTERM;
        end
        csl_pkg::LM_BLOCK, csl_pkg::LM_BLOCK_STAR, csl_pkg::LM_ATTR_PAREN: begin
          eof_err = csl_pkg::ERR_UNTERM;
        end
        default: begin
          eof_err = csl_pkg::ERR_NONE;
        end
      endcase
      res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_EOF, csl_pkg::CODE_NONE, boff_r, '0,
                                       '0, eof_err);
      nres       = nres + 3'd1;
      mode_nxt   = csl_pkg::LM_IDLE;
      pcnt_nxt   = 2'd0;
      wlen_nxt   = '0;
      acc_nxt    = '0;
      tstart_nxt = '0;
      pdepth_nxt = '0;
    end else begin
      // A lone 0x splits into the number 0 and a word starting at the x.
      if (mode_nxt == csl_pkg::LM_ZEROX && !csl_pkg::is_hex(c)) begin
        res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NUM, csl_pkg::CODE_NONE, tstart_nxt,
                                         csl_pkg::LENGTH_BITS'(1), '0, csl_pkg::ERR_NONE);
        nres        = nres + 3'd1;
        tstart_nxt  = tstart_nxt + csl_pkg::OFFSET_BITS'(1);
        wbuf_nxt[0] = prev_r;
        wlen_nxt    = csl_pkg::LENGTH_BITS'(1);
        mode_nxt    = csl_pkg::LM_WORD;
      end

      if (mode_nxt == csl_pkg::LM_OPS && pcnt_nxt == 2'd2) begin
        oh = csl_pkg::op3_code(pop0_nxt, pop1_nxt, c);
        if (oh.hit) begin
          res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_RSV, oh.code, tstart_nxt,
                                           csl_pkg::LENGTH_BITS'(3), '0, csl_pkg::ERR_NONE);
          nres     = nres + 3'd1;
          pcnt_nxt = 2'd0;
          mode_nxt = csl_pkg::LM_IDLE;
          live     = 1'b0;
        end else if (pop0_nxt == ".") begin
          oh = csl_pkg::op1_code(pop0_nxt);
          res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_RSV, oh.code, tstart_nxt,
                                           csl_pkg::LENGTH_BITS'(1), '0, csl_pkg::ERR_NONE);
          nres       = nres + 3'd1;
          tstart_nxt = tstart_nxt + csl_pkg::OFFSET_BITS'(1);
          pcnt_nxt   = 2'd1;
        end else begin
          oh = csl_pkg::op2_code(pop0_nxt, pop1_nxt);
          res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_RSV, oh.code, tstart_nxt,
                                           csl_pkg::LENGTH_BITS'(2), '0, csl_pkg::ERR_NONE);
          nres     = nres + 3'd1;
          pcnt_nxt = 2'd0;
          mode_nxt = csl_pkg::LM_IDLE;
        end
      end

      if (live && mode_nxt == csl_pkg::LM_OPS) begin
        if (pop0_nxt == "/" && c == "/") begin
          mode_nxt = csl_pkg::LM_LINE;
          pcnt_nxt = 2'd0;
          live     = 1'b0;
        end else if (pop0_nxt == "/" && c == "*") begin
          mode_nxt = csl_pkg::LM_BLOCK;
          pcnt_nxt = 2'd0;
          live     = 1'b0;
        end else if ((pop0_nxt == ">" || pop0_nxt == "<" || pop0_nxt == ".") &&
                     c == pop0_nxt) begin
          pop1_nxt = c;
          pcnt_nxt = 2'd2;
          live     = 1'b0;
        end else begin
          pcnt_nxt = 2'd0;
          mode_nxt = csl_pkg::LM_IDLE;
          oh = csl_pkg::op2_code(pop0_nxt, c);
          if (oh.hit) begin
            res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_RSV, oh.code, tstart_nxt,
                                             csl_pkg::LENGTH_BITS'(2), '0, csl_pkg::ERR_NONE);
            nres = nres + 3'd1;
            live = 1'b0;
          end else begin
            oh = csl_pkg::op1_code(pop0_nxt);
            res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_RSV, oh.code, tstart_nxt,
                                             csl_pkg::LENGTH_BITS'(1), '0, csl_pkg::ERR_NONE);
            nres = nres + 3'd1;
          end
        end
      end

      if (live && mode_nxt == csl_pkg::LM_WORD) begin
        if (csl_pkg::is_alpha(c) || csl_pkg::is_digit(c)) begin
          if (wlen_nxt < csl_pkg::LENGTH_BITS'(csl_pkg::WBUF_DEPTH)) begin
            wbuf_nxt[wlen_nxt[csl_pkg::WBUF_IDX_BITS-1:0]] = c;
          end
          wlen_nxt = csl_pkg::len_inc(wlen_nxt);
          live     = 1'b0;
        end else begin
          mode_nxt = csl_pkg::LM_IDLE;
          wc = csl_pkg::word_class(wbuf_nxt, wlen_nxt);
          case (wc.act)
            csl_pkg::WC_ATTR: mode_nxt = csl_pkg::LM_ATTR_WAIT;
            csl_pkg::WC_KW: begin
              res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_RSV, wc.code, tstart_nxt,
                                               wlen_nxt, '0, csl_pkg::ERR_NONE);
              nres = nres + 3'd1;
            end
            csl_pkg::WC_IDENT: begin
              res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_IDENT, csl_pkg::CODE_NONE,
                                               tstart_nxt, wlen_nxt, '0, csl_pkg::ERR_NONE);
              nres = nres + 3'd1;
            end
            default: mode_nxt = csl_pkg::LM_IDLE;
          endcase
        end
      end

      if (live) begin
        case (mode_nxt)
          csl_pkg::LM_DEC: begin
            if (csl_pkg::is_digit(c)) begin
              acc_nxt  = csl_pkg::sat_accum(acc_nxt, 1'b0, csl_pkg::hex_val(c));
              wlen_nxt = csl_pkg::len_inc(wlen_nxt);
              live     = 1'b0;
            end else if ((c == "x" || c == "X") && wlen_nxt == csl_pkg::LENGTH_BITS'(1) &&
                         acc_nxt == '0) begin
              mode_nxt = csl_pkg::LM_ZEROX;
              live     = 1'b0;
            end else begin
              res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NUM, csl_pkg::CODE_NONE,
                                               tstart_nxt, wlen_nxt, acc_nxt,
                                               csl_pkg::ERR_NONE);
              nres     = nres + 3'd1;
              mode_nxt = csl_pkg::LM_IDLE;
            end
          end
          csl_pkg::LM_HEX: begin
            if (csl_pkg::is_hex(c)) begin
              acc_nxt  = csl_pkg::sat_accum(acc_nxt, 1'b1, csl_pkg::hex_val(c));
              wlen_nxt = csl_pkg::len_inc(wlen_nxt);
              live     = 1'b0;
            end else begin
              res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_NUM, csl_pkg::CODE_NONE,
                                               tstart_nxt, wlen_nxt, acc_nxt,
                                               csl_pkg::ERR_NONE);
              nres     = nres + 3'd1;
              mode_nxt = csl_pkg::LM_IDLE;
            end
          end
          csl_pkg::LM_CHAR_CLOSE: begin
            mode_nxt = csl_pkg::LM_IDLE;
            if (c == "'") begin
              res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_CHAR, csl_pkg::CODE_NONE,
                                               tstart_nxt, wlen_nxt, acc_nxt,
                                               csl_pkg::ERR_NONE);
              live = 1'b0;
            end else begin
              res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_CHAR, csl_pkg::CODE_NONE,
                                               tstart_nxt, wlen_nxt, acc_nxt,
                                               csl_pkg::ERR_QUOTE);
            end
            nres = nres + 3'd1;
          end
          csl_pkg::LM_ATTR_WAIT: begin
            if (csl_pkg::is_space(c)) begin
              live = 1'b0;
            end else if (c == "(") begin
              pdepth_nxt = csl_pkg::PAREN_BITS'(1);
              mode_nxt   = csl_pkg::LM_ATTR_PAREN;
              live       = 1'b0;
            end else begin
              mode_nxt = csl_pkg::LM_IDLE;
            end
          end
          default: begin
            live = live;
          end
        endcase
      end

      if (live) begin
        case (mode_nxt)
          csl_pkg::LM_LINE: begin
            if (c == 8'h0a) mode_nxt = csl_pkg::LM_IDLE;
          end
          csl_pkg::LM_BLOCK: begin
            if (c == "*") mode_nxt = csl_pkg::LM_BLOCK_STAR;
          end
          csl_pkg::LM_BLOCK_STAR: begin
            if (c == "/") mode_nxt = csl_pkg::LM_IDLE;
            else if (c != "*") mode_nxt = csl_pkg::LM_BLOCK;
          end
          csl_pkg::LM_CHAR_OPEN: begin
            if (c == "\\") begin
              mode_nxt = csl_pkg::LM_CHAR_ESC;
            end else begin
              acc_nxt  = {{(csl_pkg::VALUE_BITS-8){1'b0}}, c};
              mode_nxt = csl_pkg::LM_CHAR_CLOSE;
            end
            wlen_nxt = csl_pkg::LENGTH_BITS'(1);
          end
          csl_pkg::LM_CHAR_ESC: begin
            acc_nxt  = {{(csl_pkg::VALUE_BITS-8){1'b0}}, csl_pkg::escape_of(c)};
            wlen_nxt = csl_pkg::LENGTH_BITS'(2);
            mode_nxt = csl_pkg::LM_CHAR_CLOSE;
          end
          csl_pkg::LM_STR: begin
            if (c == "\"") begin
              res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_STR, csl_pkg::CODE_NONE,
                                               tstart_nxt, wlen_nxt, '0, csl_pkg::ERR_NONE);
              nres     = nres + 3'd1;
              mode_nxt = csl_pkg::LM_IDLE;
            end else begin
              if (c == "\\") mode_nxt = csl_pkg::LM_STR_ESC;
              wlen_nxt = csl_pkg::len_inc(wlen_nxt);
            end
          end
          csl_pkg::LM_STR_ESC: begin
            wlen_nxt = csl_pkg::len_inc(wlen_nxt);
            mode_nxt = csl_pkg::LM_STR;
          end
          csl_pkg::LM_ZEROX: begin
            acc_nxt  = {{(csl_pkg::VALUE_BITS-4){1'b0}}, csl_pkg::hex_val(c)};
            wlen_nxt = csl_pkg::LENGTH_BITS'(3);
            mode_nxt = csl_pkg::LM_HEX;
          end
          csl_pkg::LM_ATTR_PAREN: begin
            if (c == "(") begin
              if (pdepth_nxt != csl_pkg::PAREN_MAX) pdepth_nxt = pdepth_nxt + csl_pkg::PAREN_BITS'(1);
            end else if (c == ")") begin
              if (pdepth_nxt != '0) pdepth_nxt = pdepth_nxt - csl_pkg::PAREN_BITS'(1);
              if (pdepth_nxt == '0) mode_nxt = csl_pkg::LM_IDLE;
            end
          end
          default: begin
            mode_nxt = csl_pkg::LM_IDLE;
            oh = csl_pkg::op1_code(c);
            if (csl_pkg::is_space(c)) begin
              mode_nxt = csl_pkg::LM_IDLE;
            end else if (c == "#") begin
              mode_nxt = csl_pkg::LM_LINE;
            end else if (c == "'" || c == "\"") begin
              mode_nxt   = (c == "\"") ? csl_pkg::LM_STR : csl_pkg::LM_CHAR_OPEN;
              tstart_nxt = boff_r + csl_pkg::OFFSET_BITS'(1);
              wlen_nxt   = '0;
              acc_nxt    = '0;
            end else if (oh.hit) begin
              mode_nxt   = csl_pkg::LM_OPS;
              pop0_nxt   = c;
              pcnt_nxt   = 2'd1;
              tstart_nxt = boff_r;
            end else if (csl_pkg::is_digit(c)) begin
              mode_nxt   = csl_pkg::LM_DEC;
              acc_nxt    = {{(csl_pkg::VALUE_BITS-4){1'b0}}, csl_pkg::hex_val(c)};
              wlen_nxt   = csl_pkg::LENGTH_BITS'(1);
              tstart_nxt = boff_r;
            end else if (csl_pkg::is_alpha(c)) begin
              mode_nxt    = csl_pkg::LM_WORD;
              wbuf_nxt[0] = c;
              wlen_nxt    = csl_pkg::LENGTH_BITS'(1);
              tstart_nxt  = boff_r;
            end else begin
              res[nres[1:0]] = csl_pkg::mk_res(csl_pkg::KIND_RSV, csl_pkg::CODE_NONE, boff_r,
                                               csl_pkg::LENGTH_BITS'(1),
                                               {{(csl_pkg::VALUE_BITS-8){1'b0}}, c},
                                               csl_pkg::ERR_BYTE);
              nres = nres + 3'd1;
            end
          end
        endcase
      end
    end

    for (int i = 0; i < csl_pkg::MAX_RES; i++) begin
      res[i].last = (3'(i + 1) == nres);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= csl_pkg::LM_IDLE;
      pcnt_r   <= 2'd0;
      wlen_r   <= '0;
      acc_r    <= '0;
      tstart_r <= '0;
      boff_r   <= '0;
      pdepth_r <= '0;
      prev_r   <= 8'd0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      pcnt_r   <= pcnt_nxt;
      wlen_r   <= wlen_nxt;
      acc_r    <= acc_nxt;
      tstart_r <= tstart_nxt;
      pdepth_r <= pdepth_nxt;
      boff_r   <= in_end_of_text ? '0 : boff_r + csl_pkg::OFFSET_BITS'(1);
      prev_r   <= in_end_of_text ? 8'd0 : c;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      wbuf_r <= wbuf_nxt;
      pop0_r <= pop0_nxt;
      pop1_r <= pop1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < csl_pkg::MAX_RES; i++) begin
        if (3'(i) < nres) rq_r[wptr_r + csl_pkg::RQ_PTR_BITS'(i)] <= res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      rcnt_r <= '0;
    end else begin
      if (in_fire) wptr_r <= wptr_r + csl_pkg::RQ_PTR_BITS'(nres);
      if (out_fire) rptr_r <= rptr_r + csl_pkg::RQ_PTR_BITS'(1);
      rcnt_r <= rcnt_r + (in_fire ? (csl_pkg::RQ_PTR_BITS+1)'(nres) : '0)
                - (out_fire ? (csl_pkg::RQ_PTR_BITS+1)'(1) : '0);
    end
  end

  assign head             = rq_r[rptr_r];
  assign out_valid        = rcnt_r != '0;
  assign out_token_kind   = head.kind;
  assign out_token_code   = head.code;
  assign out_start_offset = head.start;
  assign out_token_length = head.len;
  assign out_token_value  = head.value;
  assign out_error_code   = head.err;
  assign out_last_result  = head.last;

  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= (csl_pkg::RQ_PTR_BITS+1)'(csl_pkg::RQ_DEPTH))
    else $error("result queue overfilled");

  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_end_of_text |=> mode_r == csl_pkg::LM_IDLE && boff_r == '0)
    else $error("end of text did not return lexer to idle");

  a_eot_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_end_of_text |=> out_valid)
    else $error("end of text produced no result");

  a_pend_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r != 2'd0) == (mode_r == csl_pkg::LM_OPS))
    else $error("pending operator count out of step with mode");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the C source lexer. A short table of directed
// bytes comes first, then random C-like text built from tokens, comments,
// literals, dropped words, attribute groups and noise. Every accepted byte is
// run through a behavioral lexer in the bench, and every token record seen on
// the output is compared field by field with the oldest predicted record.
// ----------------------------------------------------------------------------
module tb;
  import csl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_byte;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_token_kind;
  logic [6:0]  out_token_code;
  logic [OFFSET_BITS-1:0] out_start_offset;
  logic [LENGTH_BITS-1:0] out_token_length;
  logic [VALUE_BITS-1:0]  out_token_value;
  logic [1:0]  out_error_code;
  logic        out_last_result;

  c_source_lexer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_byte(in_char_byte), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_token_kind(out_token_kind), .out_token_code(out_token_code),
    .out_start_offset(out_start_offset), .out_token_length(out_token_length),
    .out_token_value(out_token_value), .out_error_code(out_error_code),
    .out_last_result(out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  string op_txt[46] = '{">>=", "<<=", "...",
    "==", "!=", "<=", ">=", "+=", "-=", "*=", "/=", "&=", "|=", "^=", "~=",
    "++", "--", "&&", "||", ">>", "<<", "->",
    "=", ",", ".", "(", ")", "{", "}", "[", "]", "<", ">", "+", "-", "*",
    "/", "%", "^", ";", "&", "|", "~", "!", "?", ":"};
  string kw_txt[20] = '{"do", "while", "switch", "case", "default", "continue",
    "break", "for", "return", "if", "else", "struct", "enum", "union",
    "typedef", "const", "static", "extern", "sizeof", "__inline"};
  string skip_txt[4] = '{"signed", "volatile", "__extension__", "__restrict"};

  // Behavioral lexer state.
  lex_mode_t   md;
  logic [7:0]  wb [WBUF_DEPTH];
  logic [15:0] wl;
  logic [7:0]  po [2];
  int          pc;
  logic [62:0] acc;
  logic [31:0] ts;
  logic [31:0] bo;
  logic [15:0] pd;
  logic [7:0]  pb;

  result_t token_q[$];
  result_t step_toks[$];
  int      mismatches;

  function automatic string one(logic [7:0] c);
    string s;
    s = " ";
    s.putc(0, c);
    return s;
  endfunction

  function automatic int find_op(string s, int lo, int hi);
    for (int i = lo; i <= hi; i++) if (op_txt[i] == s) return i;
    return -1;
  endfunction

  function automatic logic [62:0] sat_mac(logic [62:0] a, int base, int d);
    longint unsigned lim;
    lim = (64'h7FFF_FFFF_FFFF_FFFF - d) / base;
    if (a > lim) return '1;
    return a * base + d;
  endfunction

  function automatic int hexd(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == " " || c == 8'h0a || c == 8'h09 || c == 8'h0d || c == 8'h00;
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] c);
    case (c)
      "0": return 8'd0;
      "a": return 8'd7;
      "b": return 8'd8;
      "f": return 8'd12;
      "n": return 8'd10;
      "r": return 8'd13;
      "t": return 8'd9;
      default: return c;
    endcase
  endfunction

  task automatic put_tok(logic [2:0] k, int cd, logic [31:0] st, logic [15:0] ln,
                         logic [62:0] v, logic [1:0] er);
    result_t r;
    if (step_toks.size() >= MAX_RES) return;
    r.kind = k; r.code = 7'(cd); r.start = st; r.len = ln;
    r.value = v; r.err = er; r.last = 1'b0;
    step_toks.push_back(r);
  endtask

  task automatic put_op(logic [31:0] st, string s);
    int cd;
    cd = find_op(s, 0, 45);
    put_tok(KIND_RSV, cd < 0 ? 0 : cd, st, 16'(s.len()), '0, ERR_NONE);
  endtask

  task automatic grow_len();
    if (wl != 16'hFFFF) wl++;
  endtask

  task automatic push_word(logic [7:0] c);
    if (wl < WBUF_DEPTH) wb[wl] = c;
    grow_len();
  endtask

  task automatic close_word();
    string w;
    md = LM_IDLE;
    if (wl <= 13) begin
      w = "";
      for (int i = 0; i < wl; i++) w = {w, one(wb[i])};
      foreach (skip_txt[i]) if (skip_txt[i] == w) return;
      if (w == "__attribute__") begin
        md = LM_ATTR_WAIT;
        return;
      end
      foreach (kw_txt[i]) begin
        if (kw_txt[i] == w) begin
          put_tok(KIND_RSV, KW_BASE + i, ts, wl, '0, ERR_NONE);
          return;
        end
      end
    end
    put_tok(KIND_IDENT, 0, ts, wl, '0, ERR_NONE);
  endtask

  task automatic start_tok(logic [7:0] c);
    if (blank(c)) return;
    if (c == "#") begin
      md = LM_LINE;
      return;
    end
    if (c == "'" || c == "\"") begin
      md = (c == "\"") ? LM_STR : LM_CHAR_OPEN;
      ts = bo + 1;
      wl = 0;
      acc = 0;
      return;
    end
    if (find_op(one(c), 22, 45) >= 0) begin
      md = LM_OPS; po[0] = c; pc = 1; ts = bo;
      return;
    end
    if (digit(c)) begin
      md = LM_DEC; acc = 63'(c - "0"); wl = 1; ts = bo;
      return;
    end
    if (alpha(c)) begin
      md = LM_WORD; wl = 0; push_word(c); ts = bo;
      return;
    end
    put_tok(KIND_RSV, 0, bo, 1, 63'(c), ERR_BYTE);
  endtask

  task automatic lex_byte(logic [7:0] c);
    string g;
    int cd, d;
    for (int guard = 0; guard < 6; guard++) begin
      case (md)
        LM_WORD: begin
          if (alpha(c) || digit(c)) begin
            push_word(c);
            return;
          end
          close_word();
        end
        LM_DEC: begin
          if (digit(c)) begin
            acc = sat_mac(acc, 10, c - "0");
            grow_len();
            return;
          end
          if ((c == "x" || c == "X") && wl == 1 && acc == 0) begin
            md = LM_ZEROX;
            return;
          end
          put_tok(KIND_NUM, 0, ts, wl, acc, ERR_NONE);
          md = LM_IDLE;
        end
        LM_ZEROX: begin
          d = hexd(c);
          if (d >= 0) begin
            acc = 63'(d); wl = 3; md = LM_HEX;
            return;
          end
          put_tok(KIND_NUM, 0, ts, 1, '0, ERR_NONE);
          ts = ts + 1;
          wl = 0;
          push_word(pb);
          md = LM_WORD;
        end
        LM_HEX: begin
          d = hexd(c);
          if (d >= 0) begin
            acc = sat_mac(acc, 16, d);
            grow_len();
            return;
          end
          put_tok(KIND_NUM, 0, ts, wl, acc, ERR_NONE);
          md = LM_IDLE;
        end
        LM_OPS: begin
          if (pc == 1) begin
            if (po[0] == "/" && c == "/") begin
              md = LM_LINE; pc = 0;
              return;
            end
            if (po[0] == "/" && c == "*") begin
              md = LM_BLOCK; pc = 0;
              return;
            end
            if ((po[0] == ">" || po[0] == "<" || po[0] == ".") && c == po[0]) begin
              po[1] = c; pc = 2;
              return;
            end
            g = {one(po[0]), one(c)};
            cd = find_op(g, 3, 21);
            pc = 0;
            md = LM_IDLE;
            if (cd >= 0) begin
              put_tok(KIND_RSV, cd, ts, 2, '0, ERR_NONE);
              return;
            end
            put_op(ts, one(po[0]));
          end else begin
            g = {one(po[0]), one(po[1]), one(c)};
            cd = find_op(g, 0, 2);
            if (cd >= 0) begin
              put_tok(KIND_RSV, cd, ts, 3, '0, ERR_NONE);
              pc = 0;
              md = LM_IDLE;
              return;
            end
            if (po[0] == ".") begin
              put_op(ts, ".");
              ts = ts + 1;
              pc = 1;
            end else begin
              put_op(ts, {one(po[0]), one(po[1])});
              pc = 0;
              md = LM_IDLE;
            end
          end
        end
        LM_LINE: begin
          if (c == 8'h0a) md = LM_IDLE;
          return;
        end
        LM_BLOCK: begin
          if (c == "*") md = LM_BLOCK_STAR;
          return;
        end
        LM_BLOCK_STAR: begin
          if (c == "/") md = LM_IDLE;
          else if (c != "*") md = LM_BLOCK;
          return;
        end
        LM_CHAR_OPEN: begin
          if (c == "\\") begin
            wl = 1; md = LM_CHAR_ESC;
            return;
          end
          acc = 63'(c); wl = 1; md = LM_CHAR_CLOSE;
          return;
        end
        LM_CHAR_ESC: begin
          acc = 63'(unescape(c)); wl = 2; md = LM_CHAR_CLOSE;
          return;
        end
        LM_CHAR_CLOSE: begin
          md = LM_IDLE;
          if (c == "'") begin
            put_tok(KIND_CHAR, 0, ts, wl, acc, ERR_NONE);
            return;
          end
          put_tok(KIND_CHAR, 0, ts, wl, acc, ERR_QUOTE);
        end
        LM_STR: begin
          if (c == "\"") begin
            put_tok(KIND_STR, 0, ts, wl, '0, ERR_NONE);
            md = LM_IDLE;
            return;
          end
          if (c == "\\") md = LM_STR_ESC;
          grow_len();
          return;
        end
        LM_STR_ESC: begin
          grow_len();
          md = LM_STR;
          return;
        end
        LM_ATTR_WAIT: begin
          if (blank(c)) return;
          if (c == "(") begin
            pd = 1; md = LM_ATTR_PAREN;
            return;
          end
          md = LM_IDLE;
        end
        LM_ATTR_PAREN: begin
          if (c == "(") begin
            if (pd != 16'hFFFF) pd++;
          end else if (c == ")") begin
            if (pd != 0) pd--;
            if (pd == 0) md = LM_IDLE;
          end
          return;
        end
        default: begin
          md = LM_IDLE;
          start_tok(c);
          return;
        end
      endcase
    end
  endtask

  task automatic lexer_clear();
    md = LM_IDLE; wl = 0; pc = 0; acc = 0; ts = 0; bo = 0; pd = 0; pb = 0;
  endtask

  // Advances the bench lexer by one transaction and queues its token records.
  task automatic predict_tokens(logic [7:0] c, logic eot);
    logic [1:0] er;
    step_toks.delete();
    if (eot) begin
      er = ERR_NONE;
      case (md)
        LM_WORD: close_word();
        LM_DEC, LM_HEX: put_tok(KIND_NUM, 0, ts, wl, acc, ERR_NONE);
        LM_ZEROX: begin
          put_tok(KIND_NUM, 0, ts, 1, '0, ERR_NONE);
          put_tok(KIND_IDENT, 0, ts + 1, 1, '0, ERR_NONE);
        end
        LM_OPS: begin
          if (pc == 1) put_op(ts, one(po[0]));
          else if (pc == 2) begin
            if (po[0] == ".") begin
              put_op(ts, ".");
              put_op(ts + 1, ".");
            end else put_op(ts, {one(po[0]), one(po[1])});
          end
        end
        LM_CHAR_OPEN, LM_CHAR_ESC, LM_CHAR_CLOSE: begin
          put_tok(KIND_CHAR, 0, ts, wl, acc, ERR_UNTERM);
          er = ERR_UNTERM;
        end
        LM_STR, LM_STR_ESC: begin
          put_tok(KIND_STR, 0, ts, wl, '0, ERR_UNTERM);
          er = ERR_UNTERM;
        end
        LM_BLOCK, LM_BLOCK_STAR, LM_ATTR_PAREN: er = ERR_UNTERM;
        default: ;
      endcase
      put_tok(KIND_EOF, 0, bo, 0, '0, er);
      lexer_clear();
    end else begin
      lex_byte(c);
      pb = c;
      bo = bo + 1;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endtask

  typedef struct {
    logic [7:0]  c;
    logic        eot;
    bit          chk;
    logic [2:0]  k;
    logic [6:0]  cd;
    logic [31:0] st;
    logic [15:0] ln;
    logic [62:0] v;
    logic [1:0]  er;
  } row_t;

  row_t rows[$];
  row_t stim_q[$];

  task automatic add_row(logic [7:0] c, logic eot);
    row_t r;
    r = '{c: c, eot: eot, chk: 1'b0, k: '0, cd: '0, st: '0, ln: '0, v: '0, er: '0};
    stim_q.push_back(r);
  endtask

  task automatic add_typed(logic [7:0] c, logic eot, logic [2:0] k, int cd, int st,
                           int ln, logic [62:0] v, logic [1:0] er);
    row_t r;
    r = '{c: c, eot: eot, chk: 1'b1, k: k, cd: 7'(cd), st: st, ln: ln, v: v, er: er};
    stim_q.push_back(r);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(s.getc(i), 1'b0);
  endtask

  function automatic logic [7:0] any_char(string set);
    return set.getc($urandom_range(0, set.len() - 1));
  endfunction

  task automatic add_snippet();
    string ab, hx;
    int n;
    ab = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    hx = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 15))
      0: add_text(kw_txt[$urandom_range(0, 19)]);
      1: add_text(skip_txt[$urandom_range(0, 3)]);
      2: begin
        add_text($urandom_range(0, 1) ? "__attribute__ ((a(b)(" : "__attribute__(x");
        repeat ($urandom_range(0, 3)) add_row(any_char("()a "), 1'b0);
        add_text("))");
      end
      3: begin
        add_row(any_char(ab.substr(0, 52)), 1'b0);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
        repeat (n) add_row(any_char(ab), 1'b0);
      end
      4: begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 4);
        repeat (n) add_row(any_char("0123456789"), 1'b0);
      end
      5: begin
        add_text($urandom_range(0, 1) ? "0x" : "0X");
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 4);
        repeat (n) add_row(any_char(hx), 1'b0);
      end
      6: add_text(op_txt[$urandom_range(0, 45)]);
      7: repeat ($urandom_range(1, 4)) add_text(op_txt[$urandom_range(0, 45)]);
      8: begin
        add_row("'", 1'b0);
        if ($urandom_range(0, 1)) add_row("\\", 1'b0);
        add_row(any_char("0abfnrtx'\\z"), 1'b0);
        if ($urandom_range(0, 3) != 0) add_row("'", 1'b0);
      end
      9: begin
        add_row("\"", 1'b0);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) add_row("\\", 1'b0);
          add_row(8'($urandom_range(0, 255)), 1'b0);
        end
        add_row("\"", 1'b0);
      end
      10: add_text($urandom_range(0, 1) ? "// x */\n" : "/* a ** b */");
      11: add_text("#define q 1\n");
      12: add_row(8'($urandom_range(0, 255)), 1'b0);
      13: add_row(8'($urandom_range(128, 255)), 1'b0);
      14: add_row(1'b0, 1'b1);
      default: add_row(any_char(" \t\n\r"), 1'b0);
    endcase
    if ($urandom_range(0, 2) == 0) add_row(" ", 1'b0);
  endtask

  function automatic bit field_bad(result_t e);
    return out_token_kind != e.kind || out_token_code != e.code ||
           out_start_offset != e.start || out_token_length != e.len ||
           out_token_value != e.value || out_error_code != e.err ||
           out_last_result != e.last;
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  bit calm_out;
  bit stim_done;

  initial begin
    in_valid = 1'b0;
    in_char_byte = 8'h00;
    in_end_of_text = 1'b0;
    out_ready = 1'b0;
    rst_n = 1'b0;
    mismatches = 0;
    stim_done = 1'b0;
    calm_out = 1'b0;
    lexer_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    int gap, cnt, n;
    add_typed(8'h01, 1'b0, KIND_RSV, 0, 0, 1, 1, ERR_BYTE);
    add_typed(8'hFF, 1'b0, KIND_RSV, 0, 1, 1, 255, ERR_BYTE);
    add_text(">>");
    add_typed("=", 1'b0, KIND_RSV, 0, 2, 3, 0, ERR_NONE);
    add_text("..");
    add_typed(".", 1'b0, KIND_RSV, 2, 5, 3, 0, ERR_NONE);
    add_text("<<");
    add_typed("=", 1'b0, KIND_RSV, 1, 8, 3, 0, ERR_NONE);
    add_text("'\\n");
    add_typed("'", 1'b0, KIND_CHAR, 0, 12, 2, 10, ERR_NONE);
    add_text("0x");
    add_typed(";", 1'b0, KIND_IDENT, 0, 16, 1, 0, ERR_NONE);
    add_text("\"a");
    add_typed(8'h00, 1'b1, KIND_EOF, 0, 20, 0, 0, ERR_UNTERM);
    add_row(8'h00, 1'b0);
    add_typed(8'h00, 1'b1, KIND_EOF, 0, 1, 0, 0, ERR_NONE);
    while (stim_q.size() < 485) add_snippet();
    add_row(8'h00, 1'b1);

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    cnt = 0;
    gap = $urandom_range(0, 14);
    foreach (stim_q[i]) begin
      repeat (gap) @(posedge clk);
      if (i == 240) begin
        while (token_q.size() != 0) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_char_byte <= stim_q[i].c;
      in_end_of_text <= stim_q[i].eot;
      do @(posedge clk); while (!in_ready);
      n = token_q.size();
      predict_tokens(stim_q[i].c, stim_q[i].eot);
      if (stim_q[i].chk) begin
        if (token_q.size() == n ||
            token_q[$].kind != stim_q[i].k || token_q[$].code != stim_q[i].cd ||
            token_q[$].start != stim_q[i].st || token_q[$].len != stim_q[i].ln ||
            token_q[$].value != stim_q[i].v || token_q[$].err != stim_q[i].er)
          note_mismatch($sformatf("directed row %0d disagrees with typed result", i));
      end
      cnt++;
      gap = ((cnt / 60) % 3 == 1) ? 0 : $urandom_range(0, 14);
      calm_out = ((cnt / 45) % 3 == 2);
      if (gap > 0 || i == stim_q.size() - 1) in_valid <= 1'b0;
    end
    stim_done = 1'b1;
  end

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    gap = $urandom_range(0, 14);
    forever begin
      repeat (gap) @(posedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (token_q.size() == 0) begin
        note_mismatch($sformatf("unexpected token kind %0d at offset %0d",
                                out_token_kind, out_start_offset));
      end else begin
        if (field_bad(token_q[0]))
          note_mismatch($sformatf(
            "exp k%0d c%0d s%0d l%0d v%0h e%0d t%0d got k%0d c%0d s%0d l%0d v%0h e%0d t%0d",
            token_q[0].kind, token_q[0].code, token_q[0].start, token_q[0].len,
            token_q[0].value, token_q[0].err, token_q[0].last,
            out_token_kind, out_token_code, out_start_offset, out_token_length,
            out_token_value, out_error_code, out_last_result));
        void'(token_q.pop_front());
      end
      gap = calm_out ? 0 : $urandom_range(0, 14);
      if (gap > 0) out_ready <= 1'b0;
    end
  end

  initial begin
    @(posedge clk);
    while (!stim_done || token_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
sv/csl_pkg.sv
sv/c_source_lexer.sv
dv/tb.sv
